// ===== hw/rtl/fhd_pkg.sv =====
// Shared types and constants of the frame header deframer.
package fhd_pkg;

  localparam int unsigned HeaderBytes = 36;
  localparam int unsigned CacheBytes  = 65536;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CountW      = 6;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadFlag = 2'd1;
  localparam logic [1:0] StBadSize = 2'd2;

  localparam logic [2:0] RegHeadFlag = 3'h0;
  localparam logic [2:0] RegMaxBytes = 3'h4;

  localparam logic [31:0] SizeCap = 32'(CacheBytes - HeaderBytes);

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last_of_frame;
    logic [31:0] stream_kind;
    logic [31:0] frame_kind;
    logic [63:0] frame_sequence;
    logic [63:0] frame_time;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [31:0] head_flag;
    logic [15:0] max_frame_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/fhd_front.sv =====
// Front end: accepts stream bytes, collects the header and classifies each byte.
module fhd_front import fhd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_start_i,
  input  logic       space_i,
  output logic       in_ready_o,
  output logic       push_o,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DROP    = 3'b100
  } phase_e;

  phase_e            phase_q, phase_d, phase_eff;
  logic [CountW-1:0] count_q, count_d, count_eff, count_nxt;
  logic [31:0]       left_q, left_d, left_dec;
  logic [31:0]       flag_q, flag_d;
  logic [31:0]       stream_q, stream_d;
  logic [31:0]       frame_q, frame_d;
  logic [31:0]       size_q, size_d;
  logic [63:0]       seq_q, seq_d;
  logic [63:0]       time_q, time_d;
  logic [31:0]       limit;
  logic [CountW-1:0] seq_off, time_off;
  logic              accept;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign limit      = ({16'b0, cfg_i.max_frame_bytes} < SizeCap) ?
                      {16'b0, cfg_i.max_frame_bytes} : SizeCap;
  assign seq_off    = count_eff - CountW'(20);
  assign time_off   = count_eff - CountW'(28);
  assign left_dec   = left_q - 32'd1;
  assign count_nxt  = count_eff + CountW'(1);

  always_comb begin
    phase_eff = phase_q;
    count_eff = count_q;
    if (phase_q == PH_DROP && in_start_i) begin
      phase_eff = PH_HEADER;
      count_eff = '0;
    end
  end

  always_comb begin
    flag_d   = flag_q;
    stream_d = stream_q;
    frame_d  = frame_q;
    size_d   = size_q;
    seq_d    = seq_q;
    time_d   = time_q;
    if (count_eff < CountW'(4)) begin
      flag_d[count_eff[1:0]*8 +: 8] = in_byte_i;
    end
    if (count_eff >= CountW'(8) && count_eff < CountW'(12)) begin
      stream_d[count_eff[1:0]*8 +: 8] = in_byte_i;
    end
    if (count_eff >= CountW'(12) && count_eff < CountW'(16)) begin
      frame_d[count_eff[1:0]*8 +: 8] = in_byte_i;
    end
    if (count_eff >= CountW'(16) && count_eff < CountW'(20)) begin
      size_d[count_eff[1:0]*8 +: 8] = in_byte_i;
    end
    if (count_eff >= CountW'(20) && count_eff < CountW'(28)) begin
      seq_d[seq_off[2:0]*8 +: 8] = in_byte_i;
    end
    if (count_eff >= CountW'(28) && count_eff < CountW'(HeaderBytes)) begin
      time_d[time_off[2:0]*8 +: 8] = in_byte_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    left_d  = left_q;
    push_o  = 1'b0;
    res_o   = '0;
    if (accept) begin
      unique case (phase_eff)
        PH_DROP: begin
          phase_d = PH_DROP;
        end
        PH_PAYLOAD: begin
          left_d                = left_dec;
          push_o                = 1'b1;
          res_o.payload_byte    = in_byte_i;
          res_o.byte_valid      = 1'b1;
          res_o.last_of_frame   = (left_dec == 32'd0);
          res_o.stream_kind     = stream_q;
          res_o.frame_kind      = frame_q;
          res_o.frame_sequence  = seq_q;
          res_o.frame_time      = time_q;
          res_o.status          = StOk;
          if (left_dec == 32'd0) begin
            phase_d = PH_HEADER;
            count_d = '0;
          end
        end
        PH_HEADER: begin
          phase_d = PH_HEADER;
          count_d = count_nxt;
          if (count_nxt == CountW'(4) && flag_d != cfg_i.head_flag) begin
            phase_d      = PH_DROP;
            count_d      = '0;
            push_o       = 1'b1;
            res_o.status = StBadFlag;
          end else if (count_nxt == CountW'(HeaderBytes)) begin
            count_d = '0;
            if (size_q[31] || size_q > limit) begin
              phase_d      = PH_DROP;
              push_o       = 1'b1;
              res_o.status = StBadSize;
            end else if (size_q == 32'd0) begin
              push_o               = 1'b1;
              res_o.last_of_frame  = 1'b1;
              res_o.stream_kind    = stream_d;
              res_o.frame_kind     = frame_d;
              res_o.frame_sequence = seq_d;
              res_o.frame_time     = time_d;
              res_o.status         = StOk;
            end else begin
              left_d  = size_q;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        default: begin
          phase_d = PH_HEADER;
          count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_eff == PH_HEADER) begin
      flag_q   <= flag_d;
      stream_q <= stream_d;
      frame_q  <= frame_d;
      size_q   <= size_d;
      seq_q    <= seq_d;
      time_q   <= time_d;
    end
  end

`ifndef SYNTHESIS
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != 32'd0)
    else $error("payload phase with no bytes left");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CountW'(HeaderBytes))
    else $error("header count out of range");
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.status != StOk |-> !res_o.byte_valid && !res_o.last_of_frame
      && res_o.frame_sequence == 64'd0)
    else $error("error result carries frame data");
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DROP && !in_start_i |-> !push_o && phase_d == PH_DROP)
    else $error("result or exit while dropping without packet start");
`endif

endmodule

// ===== hw/rtl/fhd_queue.sv =====
// Short queue of classified results between the front and back ends.
module fhd_queue import fhd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic space_o,
  input  logic pop_i,
  output logic avail_o,
  output res_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  res_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign space_o    = cnt_q < CntW'(QueueDepth);
  assign avail_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/fhd_back.sv =====
// Back end: output register that packs results into output beats.
module fhd_back import fhd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         avail_i,
  input  res_t         res_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [199:0] out_data_o,
  output logic [2:0]   out_user_o,
  output logic         out_last_o
);

  logic valid_q;
  res_t res_q;

  assign pop_o       = avail_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = {res_q.frame_time, res_q.frame_sequence, res_q.frame_kind,
                        res_q.stream_kind, res_q.payload_byte};
  assign out_user_o  = {res_q.status, res_q.byte_valid};
  assign out_last_o  = res_q.last_of_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hw/rtl/frame_header_deframer.sv =====
// Top level of the frame header deframer with its register port.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata: data_byte; tuser: packet_start
// m_axis    out        tdata: payload, stream, frame, sequence, time; tuser: valid, status
// APB       in         0x0 head_flag, 0x4 max_frame_bytes
//
// One byte is taken per cycle while the queue has space; a result is registered in the queue
// and then in the output register. Header bytes give a beat only for an error or empty frame,
// dropped bytes none; all bytes are held off while the queue is full. Reset returns to header
// collection; header contents are undefined until received. A stalled output fills the two-entry
// queue and the output register, then s_axis_tready drops.
module frame_header_deframer import fhd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] packet_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [39:8] stream_kind, [71:40] frame_kind,
  // [135:72] frame_sequence, [199:136] frame_time
  output logic [199:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [0] byte_valid, [2:1] status
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t cfg_q;
  logic space, push, avail, pop;
  res_t push_res, pop_res;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr)
      RegHeadFlag: prdata = cfg_q.head_flag;
      RegMaxBytes: prdata = {16'b0, cfg_q.max_frame_bytes};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_flag       <= 32'd0;
      cfg_q.max_frame_bytes <= 16'd65500;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegHeadFlag: cfg_q.head_flag       <= pwdata;
        RegMaxBytes: cfg_q.max_frame_bytes <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  fhd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser),
    .space_i    (space),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .res_o      (push_res)
  );

  fhd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .space_o     (space),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_res)
  );

  fhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .res_i       (pop_res),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== test/frame_header_deframer_tb.sv =====
// Self-checking testbench for the frame header deframer: headers, payload tagging and errors.
`timescale 1ns / 1ps

module frame_header_deframer_tb import fhd_pkg::*; ();

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned SettleCycles = 8;

  typedef enum logic [1:0] {PhHeader, PhPayload, PhDrop} deframe_phase_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] data_byte
  logic         s_axis_tuser;   // [0] packet_start
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [7:0] payload_byte, [39:8] stream_kind, [71:40] frame_kind,
  // [135:72] frame_sequence, [199:136] frame_time
  logic [199:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;   // [0] byte_valid, [2:1] status
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  frame_header_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  deframe_phase_e ph;
  logic [7:0]     hdr [HeaderBytes];
  int unsigned    hdr_cnt;
  logic [31:0]    bytes_left;
  logic [31:0]    flag_reg;
  logic [15:0]    max_reg;
  res_t           frame_beats_due [$];

  int unsigned cycles;
  int unsigned fail_count;
  int unsigned bytes_taken;
  int unsigned bytes_sent;
  int unsigned beats_seen;
  int unsigned frame_ends;
  int unsigned flag_errors;
  int unsigned size_errors;
  int unsigned stray_pct;
  logic        no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles++;

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("** frame_header_deframer: FAILED **");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 9);
    end
  end

  function automatic logic [63:0] hdr_le(int at, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = hdr[at + i];
    return v;
  endfunction

  function automatic logic [31:0] size_ceiling();
    return (32'(max_reg) < SizeCap) ? 32'(max_reg) : SizeCap;
  endfunction

  function automatic res_t tag_beat(logic [7:0] b, logic v, logic l);
    res_t r;
    r.payload_byte   = b;
    r.byte_valid     = v;
    r.last_of_frame  = l;
    r.stream_kind    = 32'(hdr_le(8, 4));
    r.frame_kind     = 32'(hdr_le(12, 4));
    r.frame_sequence = hdr_le(20, 8);
    r.frame_time     = hdr_le(28, 8);
    r.status         = StOk;
    return r;
  endfunction

  function automatic res_t error_beat(logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic logic stray_start();
    return $urandom_range(99) < stray_pct;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic st);
    logic [31:0] raw;
    if (ph == PhDrop) begin
      if (!st) return;
      ph = PhHeader;
      hdr_cnt = 0;
    end
    bytes_taken++;
    if (ph == PhPayload) begin
      if (bytes_left > 0) bytes_left--;
      frame_beats_due.push_back(tag_beat(b, 1'b1, bytes_left == 0));
      if (bytes_left == 0) begin
        ph = PhHeader;
        hdr_cnt = 0;
      end
      return;
    end
    if (hdr_cnt >= HeaderBytes) hdr_cnt = 0;
    hdr[hdr_cnt] = b;
    hdr_cnt++;
    if (hdr_cnt == 4) begin
      if (hdr_le(0, 4) != {32'h0, flag_reg}) begin
        ph = PhDrop;
        hdr_cnt = 0;
        frame_beats_due.push_back(error_beat(StBadFlag));
      end
      return;
    end
    if (hdr_cnt < HeaderBytes) return;
    hdr_cnt = 0;
    raw = 32'(hdr_le(16, 4));
    if (raw[31] || raw > size_ceiling()) begin
      ph = PhDrop;
      frame_beats_due.push_back(error_beat(StBadSize));
    end else if (raw == 0) begin
      frame_beats_due.push_back(tag_beat(8'h00, 1'b0, 1'b1));
    end else begin
      bytes_left = raw;
      ph = PhPayload;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("[%0t] mismatch on %s at beat %0d: got %h, want %h",
             $time, what, beats_seen, got, want);
  endtask

  task automatic check_beat();
    res_t want;
    beats_seen++;
    if (m_axis_tlast) frame_ends++;
    if (m_axis_tuser[2:1] == StBadFlag) flag_errors++;
    if (m_axis_tuser[2:1] == StBadSize) size_errors++;
    if (frame_beats_due.size() == 0) begin
      report_mismatch("beat with nothing due", 64'(m_axis_tdata[7:0]), '0);
      return;
    end
    want = frame_beats_due.pop_front();
    if (m_axis_tdata[7:0] !== want.payload_byte)
      report_mismatch("payload_byte", 64'(m_axis_tdata[7:0]), 64'(want.payload_byte));
    if (m_axis_tuser[0] !== want.byte_valid)
      report_mismatch("byte_valid", 64'(m_axis_tuser[0]), 64'(want.byte_valid));
    if (m_axis_tlast !== want.last_of_frame)
      report_mismatch("last_of_frame", 64'(m_axis_tlast), 64'(want.last_of_frame));
    if (m_axis_tdata[39:8] !== want.stream_kind)
      report_mismatch("stream_kind", 64'(m_axis_tdata[39:8]), 64'(want.stream_kind));
    if (m_axis_tdata[71:40] !== want.frame_kind)
      report_mismatch("frame_kind", 64'(m_axis_tdata[71:40]), 64'(want.frame_kind));
    if (m_axis_tdata[135:72] !== want.frame_sequence)
      report_mismatch("frame_sequence", m_axis_tdata[135:72], want.frame_sequence);
    if (m_axis_tdata[199:136] !== want.frame_time)
      report_mismatch("frame_time", m_axis_tdata[199:136], want.frame_time);
    if (m_axis_tuser[2:1] !== want.status)
      report_mismatch("status", 64'(m_axis_tuser[2:1]), 64'(want.status));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    int unsigned gap;
    gap = 0;
    if (!no_gaps && $urandom_range(99) < 4) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    deframe_byte(b, st);
  endtask

  task automatic send_header(input logic [31:0] flag, input logic [31:0] size,
                             input logic first_start);
    logic [287:0] hv;
    hv = {{$urandom, $urandom}, {$urandom, $urandom}, size, 32'($urandom),
          32'($urandom), 32'($urandom), flag};
    for (int i = 0; i < HeaderBytes; i++)
      send_byte(hv[8*i +: 8], (i == 0) ? first_start : stray_start());
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)), stray_start());
  endtask

  task automatic send_good_frame(input logic [31:0] size);
    send_header(flag_reg, size, (ph == PhDrop) ? 1'b1 : 1'($urandom_range(1)));
    send_payload(size);
  endtask

  // Stops feeding and lets the pipeline empty so registers can be touched safely.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_beats_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_register(input logic [2:0] a);
    logic [31:0] want;
    logic [31:0] got;
    want = (a == RegHeadFlag) ? flag_reg : 32'(max_reg);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch("register readback", 64'(got), 64'(want));
  endtask

  task automatic set_register(input logic [2:0] a, input logic [31:0] d);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (a == RegHeadFlag) flag_reg = d;
    else if (a == RegMaxBytes) max_reg = d[15:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_register(a);
  endtask

  task automatic test_register_defaults();
    check_register(RegHeadFlag);
    check_register(RegMaxBytes);
  endtask

  task automatic test_short_frames();
    send_good_frame(32'd0);
    send_header(flag_reg, 32'd2, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_good_frame(32'd1);
    send_good_frame(32'd5);
  endtask

  task automatic test_flag_mismatch();
    settle();
    set_register(RegHeadFlag, 32'hFFFF_FFFF);
    send_good_frame(32'd3);
    send_header(32'hFFFF_FFFE, 32'd4, 1'b1);
    send_payload(5);
    send_good_frame(32'd2);
    send_header(32'h7FFF_FFFF, 32'd0, 1'b1);
    send_good_frame(32'd0);
  endtask

  task automatic test_size_bounds();
    settle();
    set_register(RegMaxBytes, 32'hABCD_000A);
    send_good_frame(32'd10);
    send_header(flag_reg, 32'd11, 1'b1);
    send_payload(3);
    send_header(flag_reg, 32'h8000_0000, 1'b1);
    send_header(flag_reg, 32'hFFFF_FFFF, 1'b1);
    send_good_frame(32'd4);
    settle();
    set_register(RegMaxBytes, 32'd0);
    send_good_frame(32'd0);
    send_header(flag_reg, 32'd1, 1'b1);
    send_payload(2);
    settle();
    set_register(RegMaxBytes, 32'h0000_FFFF);
    send_header(flag_reg, SizeCap + 1, 1'b1);
    send_header(flag_reg, 32'h0000_FFFF, 1'b1);
    send_good_frame(32'd7);
  endtask

  task automatic test_stray_starts();
    stray_pct = 30;
    repeat (4) send_good_frame($urandom_range(1, 9));
    stray_pct = 0;
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] lim;
    logic [31:0] sz;
    stop_at = bytes_taken + n;
    while (bytes_taken < stop_at) begin
      pick = $urandom_range(99);
      lim = size_ceiling();
      if (pick < 80) begin
        if ($urandom_range(4) == 0) sz = $urandom_range(0, (lim < 200) ? lim : 200);
        else sz = $urandom_range(0, (lim < 12) ? lim : 12);
        send_good_frame(sz);
      end else if (pick < 87) begin
        send_header(flag_reg ^ (32'd1 << $urandom_range(31)), $urandom, 1'b1);
        send_payload($urandom_range(0, 6));
      end else if (pick < 94) begin
        if ($urandom_range(1) == 1) sz = {1'b1, 31'($urandom)};
        else sz = lim + 1 + $urandom_range(0, 500);
        send_header(flag_reg, sz, (ph == PhDrop) ? 1'b1 : 1'($urandom_range(1)));
        send_payload($urandom_range(0, 6));
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    stray_pct = 2;
    settle();
    set_register(RegHeadFlag, $urandom);
    set_register(RegMaxBytes, 32'd65500);
    run_traffic(120);
    settle();
    run_traffic(40);
    settle();
    set_register(RegHeadFlag, 32'hFFFF_FFFF);
    set_register(RegMaxBytes, $urandom_range(0, 40));
    run_traffic(170);
    settle();
    set_register(RegHeadFlag, 32'h0000_0000);
    set_register(RegMaxBytes, 32'h0000_FFFF);
    no_gaps = 1'b1;
    run_traffic(150);
    no_gaps = 1'b0;
    settle();
    set_register(RegHeadFlag, $urandom);
    set_register(RegMaxBytes, $urandom);
    run_traffic(150);
    stray_pct = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_gaps       = 1'b0;
    stray_pct     = 0;
    ph            = PhHeader;
    hdr_cnt       = 0;
    bytes_left    = '0;
    flag_reg      = '0;
    max_reg       = 16'd65500;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_defaults();
    test_short_frames();
    test_flag_mismatch();
    test_size_bounds();
    test_stray_starts();
    test_random_traffic();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_beats_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (frame_beats_due.size() != 0)
      report_mismatch("beats still due at end", 64'(frame_beats_due.size()), '0);

    $display("Sent %0d bytes; checked %0d result beats, %0d frame ends,",
             bytes_sent, beats_seen, frame_ends);
    $display("%0d bad-flag and %0d bad-size reports across several register settings.",
             flag_errors, size_errors);
    if (fail_count == 0) begin
      $display("** frame_header_deframer: PASSED **");
    end else begin
      $display("** frame_header_deframer: FAILED **");
    end
    $finish;
  end

endmodule
